/* design/tgc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types, register indexes and reset values of the touch gesture
// classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

   localparam int COORD_WIDTH_DEF = 12;
   localparam int TIME_WIDTH_DEF  = 32;

   // CSR field widths
   localparam int LONG_W     = 16;
   localparam int DIST_W     = 12;
   localparam int TAP_W      = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [LONG_W-1:0] LONG_PRESS_RST = LONG_W'(500);
   localparam logic [DIST_W-1:0] SWIPE_DIST_RST = DIST_W'(40);
   localparam logic [TAP_W-1:0]  TAP_MAX_RST    = TAP_W'(300);

   typedef enum logic [2:0] {
      GEST_NONE  = 3'd0,
      GEST_TAP   = 3'd1,
      GEST_LONG  = 3'd2,
      GEST_LEFT  = 3'd3,
      GEST_RIGHT = 3'd4,
      GEST_UP    = 3'd5,
      GEST_DOWN  = 3'd6
   } gesture_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_SWIPE_DIST = 2'd1,
      CSR_TAP_MAX    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LONG_W-1:0] long_press_ms;
      logic [DIST_W-1:0] swipe_min_dist;
      logic [TAP_W-1:0]  tap_max_ms;
   } csr_type;

endpackage

/* design/tgc_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgc_classify
// Release-time gesture decision from held time and start/last positions.
// ----------------------------------------------------------------------------
module tgc_classify #(
   parameter int COORD_WIDTH = tgc_pkg::COORD_WIDTH_DEF,
   parameter int TIME_WIDTH  = tgc_pkg::TIME_WIDTH_DEF
) (
   input  tgc_pkg::csr_type        csr,
   input  logic [COORD_WIDTH-1:0]  start_x,
   input  logic [COORD_WIDTH-1:0]  start_y,
   input  logic [COORD_WIDTH-1:0]  last_x,
   input  logic [COORD_WIDTH-1:0]  last_y,
   input  logic [TIME_WIDTH-1:0]   start_time,
   input  logic [TIME_WIDTH-1:0]   now_time,
   output tgc_pkg::gesture_type    gesture
);

   localparam int CMP_W = (COORD_WIDTH > tgc_pkg::DIST_W) ? COORD_WIDTH : tgc_pkg::DIST_W;

   logic [TIME_WIDTH-1:0]  dt;
   logic [COORD_WIDTH-1:0] adx;
   logic [COORD_WIDTH-1:0] ady;
   logic [CMP_W-1:0]       min_move;
   logic                   small_x;
   logic                   small_y;
   logic                   held_long;
   logic                   held_short;

   always_comb begin
      dt         = now_time - start_time;   // wraps with the timestamp
      adx        = (last_x >= start_x) ? (last_x - start_x) : (start_x - last_x);
      ady        = (last_y >= start_y) ? (last_y - start_y) : (start_y - last_y);
      min_move   = CMP_W'(csr.swipe_min_dist);
      small_x    = CMP_W'(adx) < min_move;
      small_y    = CMP_W'(ady) < min_move;
      held_long  = dt >= TIME_WIDTH'(csr.long_press_ms);
      held_short = dt <= TIME_WIDTH'(csr.tap_max_ms);

      if (held_long && small_x && small_y) begin
         gesture = tgc_pkg::GEST_LONG;
      end else if (!small_x || !small_y) begin
         // ties go vertical
         if (adx > ady) begin
            gesture = (last_x > start_x) ? tgc_pkg::GEST_RIGHT : tgc_pkg::GEST_LEFT;
         end else begin
            gesture = (last_y > start_y) ? tgc_pkg::GEST_DOWN : tgc_pkg::GEST_UP;
         end
      end else if (held_short) begin
         gesture = tgc_pkg::GEST_TAP;
      end else begin
         gesture = tgc_pkg::GEST_NONE;
      end
   end

endmodule

/* design/touch_gesture_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Tap / long-press / swipe recognizer over a stream of touch-panel polls.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one poll sample per beat. tuser carries the contact flag,
//    tdata carries x, y and the millisecond timestamp.
//  - rsp_ channel: exactly one result beat per request beat, in order.
//    tuser carries the gesture code and the contact-held flag, tdata the
//    gesture position and the current position (-1 when released).
//  - csr_ port: write-only, one register per cycle, write only while idle.
//  - An accepted request loads the input register, then moves on into the
//    result register once that register is free, which raises rsp_tvalid.
//    Throughput: one beat per cycle, sustained while rsp_tready stays high.
//  - The input register and the result register each hold one beat, so a
//    new request is taken while a result waits; when rsp_tready stays low
//    both fill and req_tready drops until the result is taken.
//  - Reset (synchronous, active high) empties both stages, clears the
//    contact state and loads the register defaults (500, 40, 300).
//  - Gesture is decided on the first released sample after a contact, from
//    the held time (modulo the timestamp width) and start/last positions.
// ----------------------------------------------------------------------------
module touch_gesture_classifier #(
   parameter int COORD_WIDTH = tgc_pkg::COORD_WIDTH_DEF,
   parameter int TIME_WIDTH  = tgc_pkg::TIME_WIDTH_DEF,
   localparam int REQ_W = (((2 * COORD_WIDTH + TIME_WIDTH) + 7) / 8) * 8,
   localparam int RSP_W = (((4 * COORD_WIDTH + 2) + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,  // sample_x, sample_y, time_ms, zero pad
   input  logic                              req_tuser,  // touching
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata,  // gesture_x, gesture_y, pos_x, pos_y, pad
   output logic [3:0]                        rsp_tuser,  // gesture[2:0], touching_now
   // configuration
   input  logic                              csr_we,
   input  logic [tgc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int POS_W = COORD_WIDTH + 1;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   tgc_pkg::csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_addr)
            tgc_pkg::CSR_LONG_PRESS:
               csr_in.long_press_ms  = csr_wdata[tgc_pkg::LONG_W-1:0];
            tgc_pkg::CSR_SWIPE_DIST:
               csr_in.swipe_min_dist = csr_wdata[tgc_pkg::DIST_W-1:0];
            tgc_pkg::CSR_TAP_MAX:
               csr_in.tap_max_ms     = csr_wdata[tgc_pkg::TAP_W-1:0];
            default: ;  // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.long_press_ms  <= tgc_pkg::LONG_PRESS_RST;
         csr_ff.swipe_min_dist <= tgc_pkg::SWIPE_DIST_RST;
         csr_ff.tap_max_ms     <= tgc_pkg::TAP_MAX_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // ------------------------------------------------------------------
   // Handshake: stage 1 (input reg) -> stage 2 (result reg)
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_ready;
   logic s1_ready;
   logic s1_move;

   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign s1_move    = s1_valid_ff && s2_ready;
   assign req_tready = s1_ready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      s1_valid_in  = s1_ready ? req_tvalid : s1_valid_ff;
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: input register
   // ------------------------------------------------------------------
   logic                   s1_touch_ff;
   logic [COORD_WIDTH-1:0] s1_x_ff;
   logic [COORD_WIDTH-1:0] s1_y_ff;
   logic [TIME_WIDTH-1:0]  s1_time_ff;

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_touch_ff <= req_tuser;
         s1_x_ff     <= req_tdata[COORD_WIDTH-1:0];
         s1_y_ff     <= req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
         s1_time_ff  <= req_tdata[2*COORD_WIDTH+TIME_WIDTH-1:2*COORD_WIDTH];
      end
   end

   // ------------------------------------------------------------------
   // Contact state, updated as a beat moves into the result register
   // ------------------------------------------------------------------
   logic                   active_ff, active_in;
   logic [COORD_WIDTH-1:0] start_x_ff, start_x_in;
   logic [COORD_WIDTH-1:0] start_y_ff, start_y_in;
   logic [TIME_WIDTH-1:0]  start_time_ff, start_time_in;
   logic [COORD_WIDTH-1:0] last_x_ff, last_x_in;
   logic [COORD_WIDTH-1:0] last_y_ff, last_y_in;

   tgc_pkg::gesture_type   cls_gesture;
   logic                   release_hit;

   tgc_classify #(
      .COORD_WIDTH (COORD_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_classify (
      .csr        (csr_ff),
      .start_x    (start_x_ff),
      .start_y    (start_y_ff),
      .last_x     (last_x_ff),
      .last_y     (last_y_ff),
      .start_time (start_time_ff),
      .now_time   (s1_time_ff),
      .gesture    (cls_gesture)
   );

   // release sample: its own coordinates are ignored
   assign release_hit = !s1_touch_ff && active_ff;

   always_comb begin
      active_in     = active_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      start_time_in = start_time_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      if (s1_move) begin
         active_in = s1_touch_ff;
         if (s1_touch_ff) begin
            last_x_in = s1_x_ff;
            last_y_in = s1_y_ff;
            if (!active_ff) begin
               start_x_in    = s1_x_ff;
               start_y_in    = s1_y_ff;
               start_time_in = s1_time_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         start_time_ff <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
      end else begin
         active_ff     <= active_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         start_time_ff <= start_time_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: result register
   // ------------------------------------------------------------------
   tgc_pkg::gesture_type   rsp_gesture_ff, rsp_gesture_in;
   logic [COORD_WIDTH-1:0] rsp_gx_ff, rsp_gx_in;
   logic [COORD_WIDTH-1:0] rsp_gy_ff, rsp_gy_in;
   logic                   rsp_touch_ff, rsp_touch_in;
   logic [POS_W-1:0]       rsp_pos_x_ff, rsp_pos_x_in;
   logic [POS_W-1:0]       rsp_pos_y_ff, rsp_pos_y_in;

   always_comb begin
      rsp_gesture_in = release_hit ? cls_gesture : tgc_pkg::GEST_NONE;
      // gesture position is the last held position, zero with no gesture
      if (rsp_gesture_in != tgc_pkg::GEST_NONE) begin
         rsp_gx_in = last_x_ff;
         rsp_gy_in = last_y_ff;
      end else begin
         rsp_gx_in = '0;
         rsp_gy_in = '0;
      end
      // held after this beat exactly when this beat touches
      rsp_touch_in = s1_touch_ff;
      rsp_pos_x_in = s1_touch_ff ? {1'b0, s1_x_ff} : '1;
      rsp_pos_y_in = s1_touch_ff ? {1'b0, s1_y_ff} : '1;
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_gesture_ff <= rsp_gesture_in;
         rsp_gx_ff      <= rsp_gx_in;
         rsp_gy_ff      <= rsp_gy_in;
         rsp_touch_ff   <= rsp_touch_in;
         rsp_pos_x_ff   <= rsp_pos_x_in;
         rsp_pos_y_ff   <= rsp_pos_y_in;
      end
   end

   assign rsp_tdata = RSP_W'({rsp_pos_y_ff, rsp_pos_x_ff, rsp_gy_ff, rsp_gx_ff});
   assign rsp_tuser = {rsp_touch_ff, rsp_gesture_ff};

endmodule

/* tb/tb_touch_gesture_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_gesture_classifier
// Self-checking bench for the touch gesture classifier. Poll samples go in as
// beats on the req_ stream, every result beat is checked field by field
// against a bench gesture tracker or a hand-typed result, under several
// register settings, random request gaps and random result back-pressure.
// ----------------------------------------------------------------------------
module tb_touch_gesture_classifier;

   localparam int CW       = tgc_pkg::COORD_WIDTH_DEF;
   localparam int TW       = tgc_pkg::TIME_WIDTH_DEF;
   localparam int LW       = tgc_pkg::LONG_W;
   localparam int DW       = tgc_pkg::DIST_W;
   localparam int TPW      = tgc_pkg::TAP_W;
   localparam int CSR_AW   = tgc_pkg::CSR_ADDR_W;
   localparam int CSR_DW   = tgc_pkg::CSR_DATA_W;
   localparam int DIST_PAD = CSR_DW - DW;
   localparam int REQ_W    = (((2 * CW + TW) + 7) / 8) * 8;
   localparam int RSP_W    = (((4 * CW + 2) + 7) / 8) * 8;

   localparam logic [CW:0]             NO_POS    = '1;   // -1 at 13 bits
   localparam logic [CSR_AW-1:0]       CSR_SPARE = 2'd3; // no register here
   localparam int                      HOLD_OFF  = 80;   // long sink stall
   localparam int                      N_DIR     = 25;

   // One result beat, unpacked
   typedef struct packed {
      tgc_pkg::gesture_type gesture;
      logic [CW-1:0]    gx;
      logic [CW-1:0]    gy;
      logic             touching_now;
      logic [CW:0]      px;
      logic [CW:0]      py;
   } gesture_result_type;

   // Directed table row; known rows carry the result typed in by hand
   typedef struct packed {
      logic             touching;
      logic [CW-1:0]    x;
      logic [CW-1:0]    y;
      logic [TW-1:0]    t;
      logic             known;
      gesture_result_type want;
   } sample_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               req_tuser = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [3:0]         rsp_tuser;
   logic               csr_we = 1'b0;
   logic [CSR_AW-1:0]  csr_addr = '0;
   logic [CSR_DW-1:0]  csr_wdata = '0;

   touch_gesture_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // sample_x, sample_y, time_ms
      .req_tuser  (req_tuser),   // touching
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // gesture_x, gesture_y, pos_x, pos_y, pad
      .rsp_tuser  (rsp_tuser),   // gesture[2:0], touching_now
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_touch_gesture_classifier: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Gesture tracker: bench copy of the contact state and thresholds
   // ------------------------------------------------------------------------
   logic             contact;
   logic [CW-1:0]    start_x, start_y, last_x, last_y;
   logic [TW-1:0]    start_t;
   logic [LW-1:0]    lim_long;
   logic [DW-1:0]    lim_dist;
   logic [TPW-1:0]   lim_tap;

   gesture_result_type pending_results[$];
   int               mismatches  = 0;
   int               items_sent  = 0;

   // Sender/receiver pacing controls
   logic             calm = 1'b0;    // no idling on either side
   int               hold_request = 0;
   int               hold_served  = 0;

   sample_row_type   dir_tab[N_DIR];

   // Gesture decided on the release sample, from the held time and moves
   function automatic tgc_pkg::gesture_type judge_release(input logic [TW-1:0] now);
      logic [TW-1:0] held;
      logic [CW-1:0] mx, my;
      held = now - start_t;   // wraps at the timestamp width
      mx = (last_x >= start_x) ? last_x - start_x : start_x - last_x;
      my = (last_y >= start_y) ? last_y - start_y : start_y - last_y;
      if (held >= lim_long && mx < lim_dist && my < lim_dist)
         return tgc_pkg::GEST_LONG;
      if (mx >= lim_dist || my >= lim_dist) begin
         // ties go vertical; no vertical move reads as up
         if (mx > my)
            return (last_x > start_x) ? tgc_pkg::GEST_RIGHT : tgc_pkg::GEST_LEFT;
         return (last_y > start_y) ? tgc_pkg::GEST_DOWN : tgc_pkg::GEST_UP;
      end
      if (held <= lim_tap)
         return tgc_pkg::GEST_TAP;
      return tgc_pkg::GEST_NONE;
   endfunction

   task automatic track_sample(input logic touching, input logic [CW-1:0] x, y,
                               input logic [TW-1:0] t, output gesture_result_type r);
      tgc_pkg::gesture_type g;
      g = tgc_pkg::GEST_NONE;
      if (touching) begin
         last_x = x;
         last_y = y;
         if (!contact) begin
            contact = 1'b1;
            start_x = x;
            start_y = y;
            start_t = t;
         end
      end else if (contact) begin
         // release coordinates are ignored
         contact = 1'b0;
         g = judge_release(t);
      end
      r.gesture      = g;
      r.gx           = (g != tgc_pkg::GEST_NONE) ? last_x : '0;
      r.gy           = (g != tgc_pkg::GEST_NONE) ? last_y : '0;
      r.touching_now = contact;
      r.px           = contact ? {1'b0, last_x} : NO_POS;
      r.py           = contact ? {1'b0, last_y} : NO_POS;
   endtask

   // Gap length: mostly none or short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Valid stays high into the next beat when there is no gap, so
   // back-to-back callers must not advance time between calls.
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic touching, input logic [CW-1:0] x, y,
                              input logic [TW-1:0] t, input logic known,
                              input gesture_result_type typed);
      gesture_result_type r;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= touching;
      req_tdata  <= REQ_W'({t, y, x});
      do @(posedge clock); while (!req_tready);
      track_sample(touching, x, y, t, r);
      pending_results.push_back(known ? typed : r);
      items_sent++;
      gap = calm ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and let every outstanding result come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx,
                            input logic [CSR_DW-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == tgc_pkg::CSR_LONG_PRESS)
         lim_long = val[LW-1:0];
      else if (idx == tgc_pkg::CSR_SWIPE_DIST)
         lim_dist = val[DW-1:0];
      else if (idx == tgc_pkg::CSR_TAP_MAX)
         lim_tap = val[TPW-1:0];
   endtask

   // Only called with the block drained
   task automatic program_limits(input logic [LW-1:0] lp,
                                 input logic [DW-1:0] sd,
                                 input logic [TPW-1:0] tm,
                                 input logic poke_spare);
      write_csr(tgc_pkg::CSR_LONG_PRESS, CSR_DW'(lp));
      // upper bits of the distance write fall outside the register
      write_csr(tgc_pkg::CSR_SWIPE_DIST, {DIST_PAD'($urandom_range(0, 15)), sd});
      write_csr(tgc_pkg::CSR_TAP_MAX, CSR_DW'(tm));
      if (poke_spare)
         write_csr(CSR_SPARE, CSR_DW'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Move on one axis: none, near the swipe threshold, small, or anything
   function automatic logic [CW-1:0] move_amount();
      logic [CW-1:0] m;
      case ($urandom_range(0, 3))
         0: m = '0;
         1: m = CW'(lim_dist) + CW'($urandom_range(0, 2)) - CW'(1);
         2: m = CW'($urandom_range(0, 120));
         default: m = CW'($urandom);
      endcase
      if ($urandom_range(0, 1) != 0)
         m = -m;
      return m;
   endfunction

   // Held time: around the tap and long-press limits, short, zero, up to 70000, or anything
   function automatic logic [TW-1:0] hold_time();
      case ($urandom_range(0, 5))
         0: return TW'(lim_tap) + TW'($urandom_range(0, 2)) - TW'(1);
         1: return TW'(lim_long) + TW'($urandom_range(0, 2)) - TW'(1);
         2: return TW'($urandom_range(0, 600));
         3: return TW'($urandom);
         4: return '0;
         default: return TW'($urandom_range(0, 70000));
      endcase
   endfunction

   // Press, a few held samples, release; now and then a broken one or noise
   task automatic gesture_burst();
      logic [CW-1:0] x0, y0, x1, y1;
      logic [TW-1:0] t0;
      int holds;
      if ($urandom_range(0, 9) == 0) begin
         send_sample(1'($urandom_range(0, 1)), CW'($urandom), CW'($urandom),
                     TW'($urandom), 1'b0, '0);
      end else begin
         x0    = CW'($urandom);
         y0    = CW'($urandom);
         t0    = TW'($urandom);
         x1    = x0 + move_amount();
         y1    = y0 + move_amount();
         holds = $urandom_range(0, 3);
         send_sample(1'b1, x0, y0, t0, 1'b0, '0);
         for (int i = 1; i <= holds; i++) begin
            if (i == holds)
               send_sample(1'b1, x1, y1, t0 + TW'(i), 1'b0, '0);
            else
               send_sample(1'b1, CW'($urandom), CW'($urandom), t0 + TW'(i),
                           1'b0, '0);
         end
         // missing release: the next press just continues the contact
         if ($urandom_range(0, 9) != 0)
            send_sample(1'b0, CW'($urandom), CW'($urandom), t0 + hold_time(),
                        1'b0, '0);
      end
   endtask

   task automatic random_phase(input int n);
      int target;
      target = items_sent + n;
      while (items_sent < target)
         gesture_burst();
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random ready runs and stalls, plus the long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      int hold_left, ready_left, stall_left;
      hold_left  = 0;
      ready_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_request) begin
            hold_served = hold_request;
            hold_left   = HOLD_OFF - 1;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            if (ready_left == 0 && stall_left == 0) begin
               ready_left = $urandom_range(1, 16);
               stall_left = idle_len();
            end
            if (ready_left != 0) begin
               ready_left--;
               rsp_tready <= 1'b1;
            end else begin
               stall_left--;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: every accepted beat against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      gesture_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: tuser %h tdata %h",
                   rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser[2:0] !== want.gesture) begin
               $error("gesture: expected %0d, got %0d", want.gesture, rsp_tuser[2:0]);
               mismatches++;
            end
            if (rsp_tuser[3] !== want.touching_now) begin
               $error("touching_now: expected %0d, got %0d",
                      want.touching_now, rsp_tuser[3]);
               mismatches++;
            end
            if (rsp_tdata[CW-1:0] !== want.gx) begin
               $error("gesture_x: expected %0d, got %0d", want.gx, rsp_tdata[CW-1:0]);
               mismatches++;
            end
            if (rsp_tdata[2*CW-1:CW] !== want.gy) begin
               $error("gesture_y: expected %0d, got %0d", want.gy, rsp_tdata[2*CW-1:CW]);
               mismatches++;
            end
            if (rsp_tdata[3*CW:2*CW] !== want.px) begin
               $error("pos_x: expected %0d, got %0d", $signed(want.px),
                      $signed(rsp_tdata[3*CW:2*CW]));
               mismatches++;
            end
            if (rsp_tdata[4*CW+1:3*CW+1] !== want.py) begin
               $error("pos_y: expected %0d, got %0d", $signed(want.py),
                      $signed(rsp_tdata[4*CW+1:3*CW+1]));
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // reset state and register defaults
      contact  = 1'b0;
      start_x  = '0;
      start_y  = '0;
      start_t  = '0;
      last_x   = '0;
      last_y   = '0;
      lim_long = tgc_pkg::LONG_PRESS_RST;
      lim_dist = tgc_pkg::SWIPE_DIST_RST;
      lim_tap  = tgc_pkg::TAP_MAX_RST;

      // Directed rows, under the reset limits (500 / 40 / 300)
      dir_tab = '{
         // release while idle: nothing happens
         '{1'b0, 12'd0, 12'd0, 32'd0, 1'b1,
           '{tgc_pkg::GEST_NONE, 12'd0, 12'd0, 1'b0, NO_POS, NO_POS}},
         // press at the far corner, just below the timestamp wrap
         '{1'b1, 12'd4095, 12'd4095, 32'hFFFF_FFF0, 1'b1,
           '{tgc_pkg::GEST_NONE, 12'd0, 12'd0, 1'b1, 13'd4095, 13'd4095}},
         // release across the wrap, 32 ms held: tap, release x/y ignored
         '{1'b0, 12'd123, 12'd456, 32'h0000_0010, 1'b1,
           '{tgc_pkg::GEST_TAP, 12'd4095, 12'd4095, 1'b0, NO_POS, NO_POS}},
         // held 600 ms at the origin: long press
         '{1'b1, 12'd0, 12'd0, 32'd1000, 1'b1,
           '{tgc_pkg::GEST_NONE, 12'd0, 12'd0, 1'b1, 13'd0, 13'd0}},
         '{1'b1, 12'd0, 12'd0, 32'd1200, 1'b1,
           '{tgc_pkg::GEST_NONE, 12'd0, 12'd0, 1'b1, 13'd0, 13'd0}},
         '{1'b0, 12'd0, 12'd0, 32'd1600, 1'b1,
           '{tgc_pkg::GEST_LONG, 12'd0, 12'd0, 1'b0, NO_POS, NO_POS}},
         // swipe right
         '{1'b1, 12'd100, 12'd100, 32'd2000, 1'b0, '0},
         '{1'b1, 12'd200, 12'd110, 32'd2050, 1'b0, '0},
         '{1'b0, 12'd0, 12'd0, 32'd2100, 1'b0, '0},
         // swipe left
         '{1'b1, 12'd200, 12'd200, 32'd3000, 1'b0, '0},
         '{1'b1, 12'd150, 12'd210, 32'd3010, 1'b0, '0},
         '{1'b0, 12'd7, 12'd9, 32'd3050, 1'b0, '0},
         // swipe up
         '{1'b1, 12'd300, 12'd300, 32'd3500, 1'b0, '0},
         '{1'b1, 12'd310, 12'd250, 32'd3520, 1'b0, '0},
         '{1'b0, 12'd0, 12'd0, 32'd3600, 1'b0, '0},
         // swipe down
         '{1'b1, 12'd300, 12'd300, 32'd4000, 1'b0, '0},
         '{1'b1, 12'd290, 12'd350, 32'd4030, 1'b0, '0},
         '{1'b0, 12'd0, 12'd0, 32'd4090, 1'b0, '0},
         // equal moves on both axes at the threshold: vertical
         '{1'b1, 12'd500, 12'd500, 32'd5000, 1'b0, '0},
         '{1'b1, 12'd540, 12'd540, 32'd5040, 1'b0, '0},
         '{1'b0, 12'd0, 12'd0, 32'd5100, 1'b0, '0},
         // held between the tap and long-press limits: no gesture
         '{1'b1, 12'd700, 12'd700, 32'd6000, 1'b0, '0},
         '{1'b0, 12'd0, 12'd0, 32'd6400, 1'b0, '0},
         // longest possible held time
         '{1'b1, 12'd0, 12'd4095, 32'd7000, 1'b1,
           '{tgc_pkg::GEST_NONE, 12'd0, 12'd0, 1'b1, 13'd0, 13'd4095}},
         '{1'b0, 12'd4095, 12'd0, 32'd6999, 1'b1,
           '{tgc_pkg::GEST_LONG, 12'd0, 12'd4095, 1'b0, NO_POS, NO_POS}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_sample(dir_tab[i].touching, dir_tab[i].x, dir_tab[i].y, dir_tab[i].t,
                     dir_tab[i].known, dir_tab[i].want);
      random_phase(125);

      // all limits at zero: every contact is a swipe, no-move ones read as up
      drain();
      program_limits('0, '0, '0, 1'b1);
      random_phase(100);

      // all limits at their maximum
      drain();
      program_limits('1, '1, '1, 1'b0);
      random_phase(100);

      // no idling; sink holds off long while beats keep coming, so the
      // block fills and drops req_tready
      drain();
      program_limits(LW'($urandom_range(0, 1000)), DW'($urandom_range(0, 200)),
                     TPW'($urandom_range(0, 800)), 1'b0);
      calm = 1'b1;
      hold_request++;
      random_phase(40);
      drain();
      calm = 1'b0;

      // a few mid-range settings, the last one fully random
      for (int p = 0; p < 3; p++) begin
         if (p == 2)
            program_limits(LW'($urandom), DW'($urandom), TPW'($urandom), 1'b1);
         else
            program_limits(LW'($urandom_range(0, 1000)),
                           DW'($urandom_range(0, 200)),
                           TPW'($urandom_range(0, 800)), 1'b0);
         random_phase(120);
         drain();
      end

      // settle: any stray beat still shows up in the checker
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("tb_touch_gesture_classifier: PASS");
      else
         $display("tb_touch_gesture_classifier: FAIL");
      $finish;
   end

endmodule

/* sim.f */
design/tgc_pkg.sv
design/tgc_classify.sv
design/touch_gesture_classifier.sv
tb/tb_touch_gesture_classifier.sv
